// ===== hw/rtl/dbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbd_pkg: shared types, constants and calendar tables
// Field widths, the reciprocal used for division by one hundred, and the
// month tables of a common Gregorian year.
// ----------------------------------------------------------------------------
package dbd_pkg;

   localparam int YEAR_W           = 14;
   localparam int MONTH_W          = 4;
   localparam int DAY_W            = 5;
   localparam int DIFF_W           = 22;
   localparam int DIFF_MAX         = (2 ** DIFF_W) - 1;
   localparam int YEAR_MAX_DEFAULT = 9999;

   // floor(y / 100) equals (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y.
   localparam int RECIP_100   = 5243;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = YEAR_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
      logic [8:0] v;
      unique case (m)
         4'd1:    v = 9'd0;
         4'd2:    v = 9'd31;
         4'd3:    v = 9'd59;
         4'd4:    v = 9'd90;
         4'd5:    v = 9'd120;
         4'd6:    v = 9'd151;
         4'd7:    v = 9'd181;
         4'd8:    v = 9'd212;
         4'd9:    v = 9'd243;
         4'd10:   v = 9'd273;
         4'd11:   v = 9'd304;
         4'd12:   v = 9'd334;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] v;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   v = 5'd30;
         4'd2:                                      v = 5'd28;
         default:                                   v = 5'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/days_between_dates_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// days_between_dates_top: Gregorian day distance between two dates
// Takes two dates, flags each as a real calendar date and returns the
// absolute number of days between them.
// ----------------------------------------------------------------------------
// A pair of dates is taken at every clock edge where start is high; busy is
// always low, so a new pair may follow in every cycle. The result appears
// on the rsp_ ports for one cycle, marked by rsp_strobe, and the receiver
// cannot stall it. It passes through a four-rank pipeline: the input
// register, the multiply by the reciprocal of one hundred, the day ordinals
// and validity checks, and the difference with saturation. When either date
// is invalid, rsp_day_difference is zero.
// ----------------------------------------------------------------------------
module days_between_dates_top #(
   parameter int YEAR_MAX = dbd_pkg::YEAR_MAX_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [dbd_pkg::YEAR_W-1:0]    req_first_year,
   input  wire logic [dbd_pkg::MONTH_W-1:0]   req_first_month,
   input  wire logic [dbd_pkg::DAY_W-1:0]     req_first_day,
   input  wire logic [dbd_pkg::YEAR_W-1:0]    req_second_year,
   input  wire logic [dbd_pkg::MONTH_W-1:0]   req_second_month,
   input  wire logic [dbd_pkg::DAY_W-1:0]     req_second_day,
   output logic                               rsp_strobe,
   output logic [dbd_pkg::DIFF_W-1:0]         rsp_day_difference,
   output logic                               rsp_first_valid,
   output logic                               rsp_second_valid
);

   localparam int ORD_W = $clog2(366 * (YEAR_MAX + 1));

   logic                                 s1_valid_ff, s1_valid_in;
   dbd_pkg::date_type                    s1_date_ff [2];
   dbd_pkg::date_type                    s1_date_in [2];

   logic                                 s2_valid_ff, s2_valid_in;
   dbd_pkg::date_type                    s2_date_ff [2];
   logic [dbd_pkg::QUOT_W-1:0]           s2_quot_ff [2];
   logic [dbd_pkg::QUOT_W-1:0]           s2_quot_in [2];

   logic                                 s3_valid_ff, s3_valid_in;
   logic [ORD_W-1:0]                     s3_ord_ff [2];
   logic [ORD_W-1:0]                     s3_ord_in [2];
   logic                                 s3_ok_ff [2];
   logic                                 s3_ok_in [2];

   logic                                 rsp_strobe_ff, rsp_strobe_in;
   logic [dbd_pkg::DIFF_W-1:0]           rsp_diff_ff, rsp_diff_in;
   logic                                 rsp_ok_ff [2];

   assign busy        = 1'b0;
   assign s1_valid_in = start;

   always_comb begin
      s1_date_in[0] = '{year: req_first_year, month: req_first_month,
                        day: req_first_day};
      s1_date_in[1] = '{year: req_second_year, month: req_second_month,
                        day: req_second_day};
   end

   // Stage two: quotient of the year by one hundred.
   always_comb begin
      logic [dbd_pkg::PROD_W-1:0] prod;
      s2_valid_in = s1_valid_ff;
      for (int i = 0; i < 2; i++) begin
         prod = dbd_pkg::PROD_W'(s1_date_ff[i].year)
              * dbd_pkg::PROD_W'(dbd_pkg::RECIP_100);
         s2_quot_in[i] = prod[dbd_pkg::PROD_W-1:dbd_pkg::RECIP_SHIFT];
      end
   end

   // Stage three: leap year, validity and day ordinal of each date.
   always_comb begin
      logic [dbd_pkg::YEAR_W-1:0]  rem;
      logic                        rem_zero;
      logic                        leap;
      logic [dbd_pkg::YEAR_W-1:0]  prev;
      logic [dbd_pkg::QUOT_W-1:0]  prev_100;
      logic [dbd_pkg::QUOT_W-1:0]  prev_400;
      logic [dbd_pkg::DAY_W-1:0]   len;
      logic                        year_ok;
      logic                        month_ok;
      logic                        day_ok;
      s3_valid_in = s2_valid_ff;
      for (int i = 0; i < 2; i++) begin
         rem = s2_date_ff[i].year
             - (dbd_pkg::YEAR_W'(s2_quot_ff[i]) * dbd_pkg::YEAR_W'(100));
         rem_zero = (rem == '0);
         leap = ((s2_date_ff[i].year[1:0] == 2'b00) && !rem_zero)
             || (rem_zero && (s2_quot_ff[i][1:0] == 2'b00));
         prev     = s2_date_ff[i].year - dbd_pkg::YEAR_W'(1);
         prev_100 = rem_zero ? (s2_quot_ff[i] - dbd_pkg::QUOT_W'(1)) : s2_quot_ff[i];
         prev_400 = prev_100 >> 2;

         year_ok  = (s2_date_ff[i].year != '0)
                 && (32'(s2_date_ff[i].year) <= 32'(YEAR_MAX));
         month_ok = (s2_date_ff[i].month >= dbd_pkg::MONTH_JAN)
                 && (s2_date_ff[i].month <= dbd_pkg::MONTH_DEC);
         len = ((s2_date_ff[i].month == dbd_pkg::MONTH_FEB) && leap)
             ? dbd_pkg::DAY_W'(29) : dbd_pkg::month_len(s2_date_ff[i].month);
         day_ok = (s2_date_ff[i].day != '0) && (s2_date_ff[i].day <= len);
         s3_ok_in[i] = year_ok && month_ok && day_ok;

         s3_ord_in[i] = (ORD_W'(prev) * ORD_W'(365))
                      + ORD_W'(prev >> 2)
                      - ORD_W'(prev_100)
                      + ORD_W'(prev_400)
                      + ORD_W'(dbd_pkg::month_start(s2_date_ff[i].month))
                      + ORD_W'((s2_date_ff[i].month > dbd_pkg::MONTH_FEB) && leap)
                      + ORD_W'(s2_date_ff[i].day);
      end
   end

   // Stage four: absolute difference with saturation, or zero when a date is invalid.
   always_comb begin
      logic [ORD_W-1:0] mag;
      mag = (s3_ord_ff[0] > s3_ord_ff[1]) ? (s3_ord_ff[0] - s3_ord_ff[1])
                                          : (s3_ord_ff[1] - s3_ord_ff[0]);
      rsp_strobe_in = s3_valid_ff;
      priority if (!(s3_ok_ff[0] && s3_ok_ff[1])) begin
         rsp_diff_in = '0;
      end else if (32'(mag) > 32'(dbd_pkg::DIFF_MAX)) begin
         rsp_diff_in = '1;
      end else begin
         rsp_diff_in = dbd_pkg::DIFF_W'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         s3_valid_ff   <= s3_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         s1_date_ff[i] <= s1_date_in[i];
         s2_date_ff[i] <= s1_date_ff[i];
         s2_quot_ff[i] <= s2_quot_in[i];
         s3_ord_ff[i]  <= s3_ord_in[i];
         s3_ok_ff[i]   <= s3_ok_in[i];
         rsp_ok_ff[i]  <= s3_ok_ff[i];
      end
      rsp_diff_ff <= rsp_diff_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_day_difference = rsp_diff_ff;
   assign rsp_first_valid    = rsp_ok_ff[0];
   assign rsp_second_valid   = rsp_ok_ff[1];

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for days_between_dates_top
// Pairs of dates are driven through the start/busy transfer, first a short
// directed set (calendar extremes, leap rules, broken dates), then random
// pairs that are mostly real dates close to or far from each other, with
// some broken dates and raw noise mixed in. A scoreboard predicts the
// validity flags and the day distance of every transfer and compares each
// strobed result with the oldest prediction. The sender idles at several
// rates and drains the pipeline between phases.
// ----------------------------------------------------------------------------
module testbench;

   class day_span_ledger;
      typedef struct {
         logic [dbd_pkg::DIFF_W-1:0] span;
         logic                       first_ok;
         logic                       second_ok;
      } span_type;

      span_type pending_spans[$];
      int       failures;

      function new();
         failures = 0;
      endfunction

      function bit leap_year(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      function int unsigned days_in_month(int unsigned y,
                                          logic [dbd_pkg::MONTH_W-1:0] m);
         case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            dbd_pkg::MONTH_FEB: return leap_year(y) ? 29 : 28;
            default: return 0;
         endcase
      endfunction

      function bit real_date(dbd_pkg::date_type d);
         if (d.year == 0 || d.year > dbd_pkg::YEAR_MAX_DEFAULT) return 1'b0;
         if (d.month < dbd_pkg::MONTH_JAN || d.month > dbd_pkg::MONTH_DEC) return 1'b0;
         return d.day >= 1 && d.day <= days_in_month(d.year, d.month);
      endfunction

      function int unsigned day_ordinal(dbd_pkg::date_type d);
         int unsigned p;
         int unsigned n;
         p = d.year - 1;
         n = 365 * p + p / 4 - p / 100 + p / 400;
         for (int k = 1; k < d.month; k++) begin
            n += days_in_month(d.year, dbd_pkg::MONTH_W'(k));
         end
         return n + d.day;
      endfunction

      function void note_dates(dbd_pkg::date_type a, dbd_pkg::date_type b);
         span_type    e;
         int unsigned oa;
         int unsigned ob;
         int unsigned gap_days;
         e.first_ok  = real_date(a);
         e.second_ok = real_date(b);
         gap_days = 0;
         if (e.first_ok && e.second_ok) begin
            oa = day_ordinal(a);
            ob = day_ordinal(b);
            gap_days = (oa > ob) ? oa - ob : ob - oa;
            if (gap_days > dbd_pkg::DIFF_MAX) gap_days = dbd_pkg::DIFF_MAX;
         end
         e.span = dbd_pkg::DIFF_W'(gap_days);
         pending_spans.push_back(e);
      endfunction

      function int pending();
         return pending_spans.size();
      endfunction

      function void check_span(logic [dbd_pkg::DIFF_W-1:0] span, logic first_ok,
                               logic second_ok);
         span_type e;
         if (pending_spans.size() == 0) begin
            $error("result with no transfer waiting: day_difference %0d", span);
            failures++;
            return;
         end
         e = pending_spans.pop_front();
         if (span !== e.span) begin
            $error("day_difference expected %0d actual %0d", e.span, span);
            failures++;
         end
         if (first_ok !== e.first_ok) begin
            $error("first_valid expected %0b actual %0b", e.first_ok, first_ok);
            failures++;
         end
         if (second_ok !== e.second_ok) begin
            $error("second_valid expected %0b actual %0b", e.second_ok, second_ok);
            failures++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [dbd_pkg::YEAR_W-1:0]   req_first_year = '0;
   logic [dbd_pkg::MONTH_W-1:0]  req_first_month = '0;
   logic [dbd_pkg::DAY_W-1:0]    req_first_day = '0;
   logic [dbd_pkg::YEAR_W-1:0]   req_second_year = '0;
   logic [dbd_pkg::MONTH_W-1:0]  req_second_month = '0;
   logic [dbd_pkg::DAY_W-1:0]    req_second_day = '0;
   logic                         rsp_strobe;
   logic [dbd_pkg::DIFF_W-1:0]   rsp_day_difference;
   logic                         rsp_first_valid;
   logic                         rsp_second_valid;

   day_span_ledger ledger = new();
   int             idle_pct = 0;

   days_between_dates_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_first_year     (req_first_year),
      .req_first_month    (req_first_month),
      .req_first_day      (req_first_day),
      .req_second_year    (req_second_year),
      .req_second_month   (req_second_month),
      .req_second_day     (req_second_day),
      .rsp_strobe         (rsp_strobe),
      .rsp_day_difference (rsp_day_difference),
      .rsp_first_valid    (rsp_first_valid),
      .rsp_second_valid   (rsp_second_valid)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         ledger.check_span(rsp_day_difference, rsp_first_valid, rsp_second_valid);
      end
   end

   initial begin
      #(12 * 400000);
      $display("status: fail");
      $finish;
   end

   function automatic dbd_pkg::date_type mk_date(int unsigned y, int unsigned m,
                                                 int unsigned d);
      dbd_pkg::date_type r;
      r.year  = dbd_pkg::YEAR_W'(y);
      r.month = dbd_pkg::MONTH_W'(m);
      r.day   = dbd_pkg::DAY_W'(d);
      return r;
   endfunction

   function automatic int unsigned random_year();
      int signed y;
      case ($urandom_range(3))
         0: y = $urandom_range(1, 99) * 100 + $urandom_range(0, 2) - 1;
         1: y = $urandom_range(1, 10);
         2: y = $urandom_range(dbd_pkg::YEAR_MAX_DEFAULT - 9, dbd_pkg::YEAR_MAX_DEFAULT);
         default: y = $urandom_range(1, dbd_pkg::YEAR_MAX_DEFAULT);
      endcase
      if (y < 1) y = 1;
      if (y > dbd_pkg::YEAR_MAX_DEFAULT) y = dbd_pkg::YEAR_MAX_DEFAULT;
      return y;
   endfunction

   function automatic dbd_pkg::date_type real_date_in(int unsigned y);
      dbd_pkg::date_type r;
      int unsigned       len;
      r.year  = dbd_pkg::YEAR_W'(y);
      r.month = dbd_pkg::MONTH_W'($urandom_range(1, 12));
      len = ledger.days_in_month(y, r.month);
      r.day = dbd_pkg::DAY_W'(($urandom_range(3) == 0) ? len : $urandom_range(1, len));
      return r;
   endfunction

   function automatic dbd_pkg::date_type near_date(dbd_pkg::date_type base);
      int unsigned y;
      y = base.year + $urandom_range(0, 2);
      if (y > dbd_pkg::YEAR_MAX_DEFAULT) y = dbd_pkg::YEAR_MAX_DEFAULT;
      return real_date_in(y);
   endfunction

   function automatic dbd_pkg::date_type broken_date(dbd_pkg::date_type base);
      dbd_pkg::date_type r;
      int unsigned       len;
      r = base;
      len = ledger.days_in_month(r.year, r.month);
      case ($urandom_range(4))
         0: r.day = '0;
         1: r.day = dbd_pkg::DAY_W'(len + 1);
         2: r.month = ($urandom_range(1) == 0) ? '0
                    : dbd_pkg::MONTH_W'($urandom_range(13, 15));
         3: r.year = ($urandom_range(1) == 0) ? '0
                   : dbd_pkg::YEAR_W'($urandom_range(dbd_pkg::YEAR_MAX_DEFAULT + 1,
                                                     2 ** dbd_pkg::YEAR_W - 1));
         default: begin
            r.year = dbd_pkg::YEAR_W'($urandom_range(1, 99) * 100
                                      + (($urandom_range(1) == 0) ? 0 : 1));
            if (ledger.leap_year(r.year)) r.year = r.year + dbd_pkg::YEAR_W'(1);
            r.month = dbd_pkg::MONTH_FEB;
            r.day = dbd_pkg::DAY_W'(29);
         end
      endcase
      return r;
   endfunction

   task automatic send_dates(input dbd_pkg::date_type a, input dbd_pkg::date_type b);
      if ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      start            <= 1'b1;
      req_first_year   <= a.year;
      req_first_month  <= a.month;
      req_first_day    <= a.day;
      req_second_year  <= b.year;
      req_second_month <= b.month;
      req_second_day   <= b.day;
      do @(posedge clock); while (busy);
      ledger.note_dates(a, b);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   initial begin
      dbd_pkg::date_type a;
      dbd_pkg::date_type b;
      dbd_pkg::date_type t;
      int                waited;
      int                phase_rates[4];

      phase_rates = '{0, 65, 28, 0};
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_dates(mk_date(2000, 1, 1), mk_date(2000, 1, 1));
      send_dates(mk_date(1, 1, 1), mk_date(9999, 12, 31));
      send_dates(mk_date(9999, 12, 31), mk_date(1, 1, 1));
      send_dates(mk_date(2000, 2, 29), mk_date(2000, 3, 1));
      send_dates(mk_date(1900, 2, 29), mk_date(1900, 3, 1));
      send_dates(mk_date(2024, 2, 29), mk_date(2023, 2, 28));
      send_dates(mk_date(2023, 2, 29), mk_date(2023, 2, 28));
      send_dates(mk_date(2021, 2, 10), mk_date(2021, 3, 10));
      send_dates(mk_date(1999, 12, 31), mk_date(2000, 1, 1));
      send_dates(mk_date(2010, 0, 5), mk_date(2010, 13, 5));
      send_dates(mk_date(2010, 15, 5), mk_date(2010, 12, 31));
      send_dates(mk_date(2010, 4, 0), mk_date(2010, 4, 31));
      send_dates(mk_date(2010, 4, 30), mk_date(2010, 5, 1));
      send_dates(mk_date(0, 6, 15), mk_date(10000, 6, 15));
      send_dates(mk_date(16383, 15, 31), mk_date(1, 1, 1));
      send_dates(mk_date(1, 1, 1), mk_date(16383, 15, 31));
      send_dates(mk_date(2400, 2, 29), mk_date(2100, 2, 28));
      send_dates(mk_date(2100, 2, 29), mk_date(2400, 12, 31));
      send_dates(mk_date(1600, 3, 1), mk_date(1600, 2, 28));
      send_dates(mk_date(9999, 2, 28), mk_date(9999, 3, 1));
      drain_results();

      foreach (phase_rates[p]) begin
         idle_pct = phase_rates[p];
         repeat (410) begin
            a = real_date_in(random_year());
            case ($urandom_range(9))
               0, 1, 2, 3, 4: b = real_date_in(random_year());
               5, 6, 7: b = near_date(a);
               8: b = broken_date(near_date(a));
               default: begin
                  a = mk_date($urandom_range(2 ** dbd_pkg::YEAR_W - 1),
                              $urandom_range(15), $urandom_range(31));
                  b = mk_date($urandom_range(2 ** dbd_pkg::YEAR_W - 1),
                              $urandom_range(15), $urandom_range(31));
               end
            endcase
            if ($urandom_range(1) == 0) begin
               t = a;
               a = b;
               b = t;
            end
            send_dates(a, b);
         end
         drain_results();
      end

      @(negedge clock);
      start <= 1'b0;
      waited = 0;
      while (ledger.pending() != 0 && waited < 100) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (ledger.pending() != 0) begin
         $error("%0d results never arrived", ledger.pending());
         ledger.failures++;
      end
      if (ledger.failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
